[rtl/jse_pkg.sv]
`timescale 1ns / 1ps

package jse_pkg;

  // longest expansion: opening quote plus a six-byte hex escape
  localparam int unsigned RunMax = 7;
  localparam int unsigned LenW   = 3;

  localparam logic [7:0] CharNul    = 8'h00;
  localparam logic [7:0] CharBs     = 8'h08;
  localparam logic [7:0] CharTab    = 8'h09;
  localparam logic [7:0] CharLf     = 8'h0A;
  localparam logic [7:0] CharFf     = 8'h0C;
  localparam logic [7:0] CharCr     = 8'h0D;
  localparam logic [7:0] CharSpace  = 8'h20;
  localparam logic [7:0] CharQuote  = 8'h22;
  localparam logic [7:0] CharSlash  = 8'h2F;
  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharBslash = 8'h5C;
  localparam logic [7:0] CharLowB   = 8'h62;
  localparam logic [7:0] CharLowF   = 8'h66;
  localparam logic [7:0] CharLowN   = 8'h6E;
  localparam logic [7:0] CharLowR   = 8'h72;
  localparam logic [7:0] CharLowT   = 8'h74;
  localparam logic [7:0] CharLowX   = 8'h78;
  localparam logic [7:0] CharTilde  = 8'h7E;

  typedef struct packed {
    logic [RunMax-1:0][7:0] bytes;
    logic [LenW-1:0]        len;
  } run_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] wide;
    wide = {4'h0, nib};
    if (nib < 4'd10) begin
      hex_digit = CharZero + wide;
    end else begin
      hex_digit = 8'h57 + wide;
    end
  endfunction

endpackage

[rtl/jse_expand.sv]
`timescale 1ns / 1ps

module jse_expand (
  input  logic [7:0]    char_code_i,
  input  logic          open_i,
  output jse_pkg::run_t run_o
);
  import jse_pkg::*;

  logic [RunMax-1:0][7:0] esc;
  logic [LenW-1:0]        esc_len;

  always_comb begin
    esc     = '0;
    esc_len = LenW'(1);
    case (char_code_i) inside
      CharNul: begin
        esc[0] = CharQuote;
      end
      CharQuote, CharBslash, CharSlash: begin
        esc[0]  = CharBslash;
        esc[1]  = char_code_i;
        esc_len = LenW'(2);
      end
      CharBs: begin
        esc[0]  = CharBslash;
        esc[1]  = CharLowB;
        esc_len = LenW'(2);
      end
      CharFf: begin
        esc[0]  = CharBslash;
        esc[1]  = CharLowF;
        esc_len = LenW'(2);
      end
      CharLf: begin
        esc[0]  = CharBslash;
        esc[1]  = CharLowN;
        esc_len = LenW'(2);
      end
      CharCr: begin
        esc[0]  = CharBslash;
        esc[1]  = CharLowR;
        esc_len = LenW'(2);
      end
      CharTab: begin
        esc[0]  = CharBslash;
        esc[1]  = CharLowT;
        esc_len = LenW'(2);
      end
      [CharSpace:CharTilde]: begin
        esc[0] = char_code_i;
      end
      default: begin
        esc[0]  = CharBslash;
        esc[1]  = CharLowX;
        esc[2]  = CharZero;
        esc[3]  = CharZero;
        esc[4]  = hex_digit(char_code_i[7:4]);
        esc[5]  = hex_digit(char_code_i[3:0]);
        esc_len = LenW'(6);
      end
    endcase
  end

  // no string open yet: opening quote goes first
  always_comb begin
    if (open_i) begin
      run_o.bytes = esc;
      run_o.len   = esc_len;
    end else begin
      run_o.bytes[0] = CharQuote;
      for (int k = 1; k < RunMax; k++) begin
        run_o.bytes[k] = esc[k-1];
      end
      run_o.len = esc_len + LenW'(1);
    end
  end

endmodule

[rtl/json_string_escape_encoder.sv]
`timescale 1ns / 1ps

// Escapes a stream of zero-terminated strings into quoted text, one output
// byte per cycle while the output is not stalled. Each input byte expands
// into 1 to 7 output bytes; a run drains from a shift buffer into the output
// register, and the input stalls until the last byte of the run moves out.
// Plain printable bytes inside a string flow at one per cycle while the
// output is not stalled. Each byte of a run is registered in the shift buffer
// and then in the output register; last_of_run_o flags the last of each run.

module json_string_escape_encoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] char_code_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       last_of_run_o
);
  import jse_pkg::*;

  run_t                   run;
  logic                   open_q, open_d;
  logic [RunMax-1:0][7:0] buf_q, buf_d;
  logic [LenW-1:0]        rem_q, rem_d;
  logic                   out_v_q, out_v_d;
  logic [7:0]             out_byte_q, out_byte_d;
  logic                   out_last_q, out_last_d;
  logic                   buf_v, buf_last, move, accept;

  jse_expand u_expand (
    .char_code_i (char_code_i),
    .open_i      (open_q),
    .run_o       (run)
  );

  assign buf_v    = (rem_q != '0);
  assign buf_last = (rem_q == LenW'(1));
  assign move     = buf_v && (!out_v_q || !out_stall_i);
  // take a new request once the buffer frees up this cycle
  assign in_stall_o = buf_v && !(move && buf_last);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    open_d = open_q;
    buf_d  = buf_q;
    rem_d  = rem_q;
    if (accept) begin
      open_d = (char_code_i != CharNul);
      buf_d  = run.bytes;
      rem_d  = run.len;
    end else if (move) begin
      for (int k = 0; k < RunMax - 1; k++) begin
        buf_d[k] = buf_q[k+1];
      end
      buf_d[RunMax-1] = '0;
      rem_d = rem_q - LenW'(1);
    end
  end

  always_comb begin
    out_v_d    = out_v_q;
    out_byte_d = out_byte_q;
    out_last_d = out_last_q;
    if (move) begin
      out_v_d    = 1'b1;
      out_byte_d = buf_q[0];
      out_last_d = buf_last;
    end else if (!out_stall_i) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q  <= 1'b0;
      rem_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      open_q  <= open_d;
      rem_q   <= rem_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q      <= buf_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o   = out_v_q;
  assign out_byte_o    = out_byte_q;
  assign last_of_run_o = out_last_q;

endmodule

[rtl/jse_checker.sv]
`timescale 1ns / 1ps

module jse_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [7:0] char_code_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_byte_o,
  input logic       last_of_run_o
);
  import jse_pkg::*;

  logic in_acc;
  logic out_acc;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_byte_o) && $stable(last_of_run_o))
    else $error("output payload changed while stalled");

  // bytes ahead of the end of a run come from quotes or escape prefixes only
  a_mid_run_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !last_of_run_o |->
      (out_byte_o == CharQuote) || (out_byte_o == CharBslash) ||
      (out_byte_o == CharLowX) ||
      ((out_byte_o >= CharZero) && (out_byte_o <= 8'h39)) ||
      ((out_byte_o >= 8'h61) && (out_byte_o <= CharLowF)))
    else $error("unexpected byte inside an escape run");

  // input backpressure only starts right after a request was taken
  a_stall_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_acc))
    else $error("input stall raised without a preceding request");

endmodule

bind json_string_escape_encoder jse_checker u_jse_checker (.*);
